[hdl/motor_feedback_frame_parser_macros.svh]
// Assertion macros shared by the frame parser's checker.
// No dependencies; include by bare file name.
`ifndef MOTOR_FEEDBACK_FRAME_PARSER_MACROS_SVH
`define MOTOR_FEEDBACK_FRAME_PARSER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define MFP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define MFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mfp_pkg.sv]
// Types and constants for the motor feedback frame parser.
// No dependencies; used by the check logic, the top level and the checker.
package mfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int RAW_W    = 16;
    localparam int DIFF_W   = 13;
    localparam int POS_W    = 14;
    localparam int STAT_W   = 3;
    localparam int BPOS_W   = 3;
    localparam int IDX_W    = 1;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;
    localparam int OUT_PAD_W   = TDATA_OUT_W - 1 - POS_W - STAT_W;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h3E;
    localparam logic [RAW_W-1:0]  RAW_LIMIT  = 16'd4096;
    localparam logic [BYTE_W-1:0] YAW_ID_RST   = 8'd1;
    localparam logic [BYTE_W-1:0] PITCH_ID_RST = 8'd2;

    // byte positions within a frame
    localparam logic [BPOS_W-1:0] BP_START = 3'd0;
    localparam logic [BPOS_W-1:0] BP_B1    = 3'd1;
    localparam logic [BPOS_W-1:0] BP_ID    = 3'd2;
    localparam logic [BPOS_W-1:0] BP_B3    = 3'd3;
    localparam logic [BPOS_W-1:0] BP_HSUM  = 3'd4;
    localparam logic [BPOS_W-1:0] BP_RAWLO = 3'd5;
    localparam logic [BPOS_W-1:0] BP_RAWHI = 3'd6;
    localparam logic [BPOS_W-1:0] BP_DSUM  = 3'd7;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_YAW_ID   = 1'b0;
    localparam logic [IDX_W-1:0] CFG_PITCH_ID = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_HDR_SUM  = 3'd1,
        ST_DATA_SUM = 3'd2,
        ST_RANGE    = 3'd3,
        ST_MOTOR    = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic              hdr_ok;
        logic [BYTE_W-1:0] motor_id;
        logic [RAW_W-1:0]  raw;
        logic [BYTE_W-1:0] dsum;
    } frame_acc_t;

    typedef struct packed {
        logic              motor_select;
        logic [POS_W-1:0]  position;
        frame_status_t     status;
    } frame_result_t;

endpackage

[hdl/mfp_frame_check.sv]
// Final frame checks: sums, range, motor id match and position conversion.
// Depends on mfp_pkg.
module mfp_frame_check (
    input  mfp_pkg::frame_acc_t           acc,
    input  logic [mfp_pkg::BYTE_W-1:0]    last_byte,
    input  logic [mfp_pkg::BYTE_W-1:0]    yaw_id,
    input  logic [mfp_pkg::BYTE_W-1:0]    pitch_id,
    output mfp_pkg::frame_result_t        result
);
    import mfp_pkg::*;

    logic              over_limit;
    logic [DIFF_W-1:0] diff;

    assign over_limit = acc.raw > RAW_LIMIT;
    assign diff       = RAW_LIMIT[DIFF_W-1:0] - acc.raw[DIFF_W-1:0];

    always_comb begin
        result.motor_select = 1'b0;
        result.position     = '0;
        result.status       = ST_OK;
        if (!acc.hdr_ok) begin
            result.status = ST_HDR_SUM;
        end else if (acc.dsum != last_byte) begin
            result.status = ST_DATA_SUM;
        end else if (over_limit) begin
            result.status = ST_RANGE;
        end else if (acc.motor_id == yaw_id) begin
            result.position = {diff, 1'b0};
        end else if (acc.motor_id == pitch_id) begin
            result.motor_select = 1'b1;
            result.position     = {diff, 1'b0};
        end else begin
            result.status = ST_MOTOR;
        end
    end

endmodule

[hdl/motor_feedback_frame_parser.sv]
// Motor feedback frame parser top level: byte collection, output register, id registers.
// Depends on mfp_pkg and mfp_frame_check.
//
//  channel | dir | beat payload                               | handshake
//  s_      | in  | rx_byte                                    | tvalid/tready
//  m_      | out | motor_select, position, frame_status       | tvalid/tready
//  cfg_    | in  | register index, data                       | we only
//
// One byte per cycle unless stalled; a result is valid the cycle after the eighth byte.
// Sums are accumulated as bytes arrive, so the final check is one short compare stage.
// s_tready drops only while a result is held and m_tready is low.
// Synchronous active-low reset: hunting, no result pending, ids back to 1 and 2.
module motor_feedback_frame_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mfp_pkg::TDATA_IN_W-1:0]     s_tdata,  // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mfp_pkg::TDATA_OUT_W-1:0]    m_tdata,  // [0] motor_select,
                                                         // [14:1] position,
                                                         // [17:15] frame_status
    input  logic                               cfg_we,
    input  logic [mfp_pkg::IDX_W-1:0]          cfg_index,
    input  logic [mfp_pkg::BYTE_W-1:0]         cfg_data
);
    import mfp_pkg::*;

    logic                   in_frame_reg, in_frame_next;
    logic [BPOS_W-1:0]      bpos_reg, bpos_next;
    logic                   m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]      yaw_id_reg, yaw_id_next;
    logic [BYTE_W-1:0]      pitch_id_reg, pitch_id_next;
    logic [BYTE_W-1:0]      hsum_reg, hsum_next;
    frame_acc_t             acc_reg, acc_next;
    frame_result_t          res_reg, res_next;
    frame_result_t          check_res;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   s_accept;
    logic                   frame_done;

    assign rx_byte    = s_tdata[BYTE_W-1:0];
    assign s_tready   = !m_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign frame_done = s_accept && in_frame_reg && (bpos_reg == BP_DSUM);

    mfp_frame_check u_check (
        .acc       (acc_reg),
        .last_byte (rx_byte),
        .yaw_id    (yaw_id_reg),
        .pitch_id  (pitch_id_reg),
        .result    (check_res)
    );

    always_comb begin
        in_frame_next = in_frame_reg;
        bpos_next     = bpos_reg;
        hsum_next     = hsum_reg;
        acc_next      = acc_reg;
        if (s_accept) begin
            if (!in_frame_reg) begin
                if (rx_byte == START_BYTE) begin
                    in_frame_next = 1'b1;
                    bpos_next     = BP_B1;
                    hsum_next     = rx_byte;
                end
            end else begin
                bpos_next = bpos_reg + 1'b1;
                case (bpos_reg)
                    BP_B1, BP_B3: begin
                        hsum_next = hsum_reg + rx_byte;
                    end
                    BP_ID: begin
                        hsum_next        = hsum_reg + rx_byte;
                        acc_next.motor_id = rx_byte;
                    end
                    BP_HSUM: begin
                        acc_next.hdr_ok = (hsum_reg == rx_byte);
                    end
                    BP_RAWLO: begin
                        acc_next.raw[BYTE_W-1:0] = rx_byte;
                    end
                    BP_RAWHI: begin
                        acc_next.raw[RAW_W-1:BYTE_W] = rx_byte;
                        acc_next.dsum = acc_reg.raw[BYTE_W-1:0] + rx_byte;
                    end
                    BP_DSUM: begin
                        in_frame_next = 1'b0;
                        bpos_next     = BP_START;
                    end
                    default: begin
                        in_frame_next = 1'b0;
                        bpos_next     = BP_START;
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        res_next     = res_reg;
        if (frame_done) begin
            m_valid_next = 1'b1;
            res_next     = check_res;
        end
    end

    always_comb begin
        yaw_id_next   = yaw_id_reg;
        pitch_id_next = pitch_id_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_YAW_ID:   yaw_id_next   = cfg_data;
                CFG_PITCH_ID: pitch_id_next = cfg_data;
                default: begin
                    yaw_id_next = yaw_id_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            bpos_reg     <= BP_START;
            m_valid_reg  <= 1'b0;
            yaw_id_reg   <= YAW_ID_RST;
            pitch_id_reg <= PITCH_ID_RST;
        end else begin
            in_frame_reg <= in_frame_next;
            bpos_reg     <= bpos_next;
            m_valid_reg  <= m_valid_next;
            yaw_id_reg   <= yaw_id_next;
            pitch_id_reg <= pitch_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        hsum_reg <= hsum_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_reg.status, res_reg.position,
                       res_reg.motor_select};

endmodule

[hdl/mfp_checker.sv]
// Port-level checks for the motor feedback frame parser, bound to the top level.
// Depends on mfp_pkg and motor_feedback_frame_parser_macros.svh.
`include "motor_feedback_frame_parser_macros.svh"

module mfp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mfp_pkg::TDATA_OUT_W-1:0]   m_tdata
);
    import mfp_pkg::*;

    logic                s_beat;
    logic                m_beat;
    logic                m_sel;
    logic [POS_W-1:0]    m_pos;
    logic [STAT_W-1:0]   m_stat;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;
    assign m_sel  = m_tdata[0];
    assign m_pos  = m_tdata[POS_W:1];
    assign m_stat = m_tdata[POS_W+STAT_W:POS_W+1];

    `MFP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
    `MFP_ASSERT_SAME(a_rise_src, aclk, aresetn, $rose(m_tvalid),
        $past(s_beat), "result appeared without an input beat")
    `MFP_ASSERT_NEXT(a_drain, aclk, aresetn, m_beat && !s_beat,
        !m_tvalid, "result repeated after being taken")
    `MFP_ASSERT_SAME(a_bad_zero, aclk, aresetn, m_tvalid && (m_stat != ST_OK),
        (m_pos == '0) && !m_sel, "failed frame carries motor or position")
    `MFP_ASSERT_SAME(a_ok_range, aclk, aresetn, m_tvalid && (m_stat == ST_OK),
        (m_pos <= {RAW_LIMIT[DIFF_W-1:0], 1'b0}), "position beyond full scale")

endmodule

bind motor_feedback_frame_parser mfp_checker u_mfp_checker (.*);

[test/tb.sv]
// Self-checking bench for motor_feedback_frame_parser: byte stream in, frame results out.
// Depends on mfp_pkg and the parser RTL; predicts each result from the accepted bytes.
`timescale 1ns / 1ps

module tb;
    import mfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 950;

    class frame_tracker;
        logic [BYTE_W-1:0] yaw_id;
        logic [BYTE_W-1:0] pitch_id;
        logic              in_frame;
        logic [BPOS_W-1:0] next_pos;
        logic [BYTE_W-1:0] held [8];
        frame_result_t     due_results [$];
        int                mismatches;

        function new();
            yaw_id     = YAW_ID_RST;
            pitch_id   = PITCH_ID_RST;
            in_frame   = 1'b0;
            next_pos   = BP_START;
            mismatches = 0;
        endfunction

        function void set_id(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            if (idx == CFG_YAW_ID)
                yaw_id = val;
            else
                pitch_id = val;
        endfunction

        // one accepted byte; a completed frame queues its expected result
        function void take_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] hsum;
            logic [BYTE_W-1:0] dsum;
            logic [RAW_W-1:0]  raw;
            frame_result_t     r;
            if (!in_frame) begin
                if (b == START_BYTE) begin
                    held[BP_START] = b;
                    next_pos = BP_B1;
                    in_frame = 1'b1;
                end
                return;
            end
            held[next_pos] = b;
            if (next_pos != BP_DSUM) begin
                next_pos = next_pos + 1'b1;
                return;
            end
            next_pos = BP_START;
            in_frame = 1'b0;
            hsum = 8'(held[BP_START] + held[BP_B1] + held[BP_ID] + held[BP_B3]);
            dsum = 8'(held[BP_RAWLO] + held[BP_RAWHI]);
            raw  = {held[BP_RAWHI], held[BP_RAWLO]};
            r.motor_select = 1'b0;
            r.position     = '0;
            r.status       = ST_OK;
            if (hsum != held[BP_HSUM])
                r.status = ST_HDR_SUM;
            else if (dsum != held[BP_DSUM])
                r.status = ST_DATA_SUM;
            else if (raw > RAW_LIMIT)
                r.status = ST_RANGE;
            else if (held[BP_ID] == yaw_id)
                r.position = POS_W'((RAW_LIMIT - raw) * 2);
            else if (held[BP_ID] == pitch_id) begin
                r.motor_select = 1'b1;
                r.position     = POS_W'((RAW_LIMIT - raw) * 2);
            end else
                r.status = ST_MOTOR;
            due_results.push_back(r);
        endfunction

        function void match_result(logic [TDATA_OUT_W-1:0] beat);
            frame_result_t want;
            if (due_results.size() == 0) begin
                $error("result beat 0x%06h with nothing due", beat);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (beat[0] !== want.motor_select) begin
                $error("motor_select expected %0d actual %0d", want.motor_select, beat[0]);
                mismatches++;
            end
            if (beat[14:1] !== want.position) begin
                $error("position expected %0d actual %0d", want.position, beat[14:1]);
                mismatches++;
            end
            if (beat[17:15] !== want.status) begin
                $error("frame_status expected %0d actual %0d", want.status, beat[17:15]);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;

    frame_tracker tracker = new();
    int           cycle_count = 0;
    int           burst_left = 0;
    int           bytes_sent = 0;

    motor_feedback_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result(m_tdata);
    end

    // receiver: always ready, random, or long stalls, switching every so often
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left == 0) begin
                        m_tready  <= ~m_tready;
                        hold_left = $urandom_range(1, 12);
                    end
                    hold_left--;
                end
            endcase
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [RAW_W-1:0] raw,
                              input logic [BYTE_W-1:0] hdr_flip,
                              input logic [BYTE_W-1:0] data_flip,
                              input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b3);
        logic [BYTE_W-1:0] fb [8];
        fb[BP_START] = START_BYTE;
        fb[BP_B1]    = b1;
        fb[BP_ID]    = id;
        fb[BP_B3]    = b3;
        fb[BP_HSUM]  = 8'(START_BYTE + b1 + id + b3) ^ hdr_flip;
        fb[BP_RAWLO] = raw[7:0];
        fb[BP_RAWHI] = raw[15:8];
        fb[BP_DSUM]  = 8'(raw[7:0] + raw[15:8]) ^ data_flip;
        for (int i = 0; i < 8; i++)
            send_byte(fb[i]);
    endtask

    // finish any open frame, then hold off until every result is in
    task automatic settle();
        while (tracker.in_frame)
            send_byte(8'h00);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.due_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_id(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tracker.set_id(idx, val);
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return RAW_LIMIT;
            2: return RAW_LIMIT + 1'b1;
            3: return 16'hFFFF;
            4, 5: return RAW_W'($urandom_range(4097, 65535));
            default: return RAW_W'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic random_traffic(input int byte_goal);
        logic [BYTE_W-1:0] id;
        int                kind;
        while (bytes_sent < byte_goal) begin
            case ($urandom_range(0, 5))
                0, 1: id = tracker.yaw_id;
                2, 3: id = tracker.pitch_id;
                default: id = 8'($urandom);
            endcase
            kind = $urandom_range(0, 19);
            if (kind < 14)
                send_frame(id, pick_raw(), 8'h00, 8'h00, 8'($urandom), 8'($urandom));
            else if (kind < 16)
                send_frame(id, pick_raw(), 8'($urandom_range(1, 255)), 8'h00,
                           8'($urandom), 8'($urandom));
            else if (kind < 18)
                send_frame(id, pick_raw(), 8'h00, 8'($urandom_range(1, 255)),
                           8'($urandom), 8'($urandom));
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] yaw_val;
        logic [BYTE_W-1:0] pitch_val;
        int                goal;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: hunting noise, extremes, each status, start byte inside a frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3D);
        send_frame(8'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'd2, RAW_LIMIT, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_frame(8'd1, 16'd1234, 8'h5A, 8'h00, 8'h12, 8'h34);
        send_frame(8'd2, 16'd77, 8'h00, 8'h80, 8'hA5, 8'h5A);
        send_frame(8'd1, RAW_LIMIT + 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'd9, 16'd100, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'd2, 16'd2048, 8'h00, 8'h00, START_BYTE, START_BYTE);
        settle();

        // phases: reset ids, both extremes, equal ids, then random ids
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin yaw_val = YAW_ID_RST; pitch_val = PITCH_ID_RST; end
                1: begin yaw_val = 8'd0;   pitch_val = 8'd255; end
                2: begin yaw_val = 8'd255; pitch_val = 8'd0;   end
                3: begin yaw_val = 8'd7;   pitch_val = 8'd7;   end
                default: begin yaw_val = 8'($urandom); pitch_val = 8'($urandom); end
            endcase
            if (phase != 0) begin
                write_id(CFG_YAW_ID, yaw_val);
                write_id(CFG_PITCH_ID, pitch_val);
            end
            if (phase == 3)
                send_frame(8'd7, 16'd10, 8'h00, 8'h00, 8'h01, 8'h02);
            goal = 80 + (phase + 1) * (BYTE_TARGET - 80) / 7;
            random_traffic(goal);
            settle();
        end

        repeat (10) @(negedge aclk);
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
